@@ rtl/core/ufd_pkg.sv @@
// Shared types and constants for the update frame deframer.
package ufd_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 1024;
  localparam int unsigned HDR_BYTES = 16;
  localparam logic [31:0] HDR_VERSION = 32'd1;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_FRAME_MAGIC = 1'b0;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_REPLY   = 2'd2,
    PH_FAILED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic       reply_taken;
    logic       reset_request;
    logic [7:0] byte_data;
    logic       byte_valid;
  } item_t;

  typedef struct packed {
    logic        frame_done;
    logic        header_fault;
    logic [10:0] frame_length;
    logic [31:0] frame_opcode;
    logic [9:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        payload_strobe;
    phase_t      phase;
    logic        consumed;
  } result_t;

endpackage

@@ rtl/core/ufd_regs.sv @@
// Configuration register file with an APB-style write and read port.
module ufd_regs
  import ufd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [31:0]        frame_magic
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= '0;
    end else if (wr_en && (paddr[2] == REG_FRAME_MAGIC)) begin
      frame_magic <= pwdata;
    end
  end

  always_comb begin
    if (paddr[2] == REG_FRAME_MAGIC) begin
      prdata = frame_magic;
    end else begin
      prdata = '0;
    end
  end

endmodule

@@ rtl/core/ufd_parser.sv @@
// Frame parser state and the per-byte header, payload and reply logic.
module ufd_parser
  import ufd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] frame_magic,
  input  logic        advance,
  input  item_t       item,
  output result_t     result
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned LEN_W = (CNT_W > 11) ? CNT_W : 11;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] fill_inc;
  logic [31:0]      opcode_word, opcode_word_next;
  logic [LEN_W-1:0] payload_len, payload_len_next;
  logic             reply_pending, reply_pending_next;
  logic [7:0]       hdr_store [HDR_BYTES-1];
  logic [8*HDR_BYTES-1:0] hdr_flat;
  logic [CNT_W+9:0] fill_ext;
  logic [CNT_W-1:0] fill_after;
  logic             hdr_take;
  logic             hdr_write;
  logic             pay_take;
  logic             hdr_bad;
  logic [31:0]      magic_word, version_word, len_word;

  assign fill_inc = fill_count + CNT_W'(1);
  assign fill_ext = {10'b0, fill_count};

  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) begin
      hdr_flat[8*i +: 8] = hdr_store[i];
    end
    hdr_flat[8*(HDR_BYTES-1) +: 8] = item.byte_data;
  end

  assign magic_word   = hdr_flat[31:0];
  assign version_word = hdr_flat[63:32];
  assign len_word     = hdr_flat[127:96];
  assign hdr_bad      = (magic_word != frame_magic) || (version_word != HDR_VERSION)
                        || (len_word > 32'(PAYLOAD_BYTES));

  assign hdr_take  = !item.reset_request && (phase == PH_HEADER) && item.byte_valid
                     && (fill_count < CNT_W'(HDR_BYTES));
  assign hdr_write = hdr_take && (fill_count < CNT_W'(HDR_BYTES - 1));
  assign pay_take  = !item.reset_request && (phase == PH_PAYLOAD) && item.byte_valid
                     && (LEN_W'(fill_count) < payload_len);
  assign fill_after = pay_take ? fill_inc : fill_count;

  always_comb begin
    phase_next         = phase;
    fill_count_next    = fill_count;
    opcode_word_next   = opcode_word;
    payload_len_next   = payload_len;
    reply_pending_next = reply_pending || item.reply_taken;
    result             = '0;
    if (item.reset_request) begin
      reply_pending_next = 1'b0;
      fill_count_next    = '0;
      phase_next         = PH_HEADER;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (hdr_take) begin
            result.consumed = 1'b1;
            fill_count_next = fill_inc;
            if (fill_count == CNT_W'(HDR_BYTES - 1)) begin
              opcode_word_next = hdr_flat[95:64];
              payload_len_next = len_word[LEN_W-1:0];
              if (hdr_bad) begin
                result.header_fault = 1'b1;
                phase_next          = PH_FAILED;
              end else begin
                fill_count_next = '0;
                phase_next      = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_take) begin
            result.consumed       = 1'b1;
            result.payload_strobe = 1'b1;
            result.payload_byte   = item.byte_data;
            result.payload_index  = fill_ext[9:0];
          end
          fill_count_next = fill_after;
          if (LEN_W'(fill_after) >= payload_len) begin
            result.frame_done = 1'b1;
            phase_next        = PH_REPLY;
          end
        end
        PH_REPLY: begin
          if (reply_pending || item.reply_taken) begin
            reply_pending_next = 1'b0;
            fill_count_next    = '0;
            phase_next         = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
    end
    result.phase        = phase_next;
    result.frame_opcode = opcode_word_next;
    result.frame_length = payload_len_next[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      fill_count    <= '0;
      opcode_word   <= '0;
      payload_len   <= '0;
      reply_pending <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      fill_count    <= fill_count_next;
      opcode_word   <= opcode_word_next;
      payload_len   <= payload_len_next;
      reply_pending <= reply_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hdr_write) begin
      hdr_store[fill_count[3:0]] <= item.byte_data;
    end
  end

endmodule

@@ rtl/core/update_frame_deframer.sv @@
// A transfer held in the input register moves to the result register at the edge at which
// the result register is free or drains.
// Throughput: one input transfer per cycle while the result is not stalled, set by the input and result registers.
// A stalled result holds the input register, and s_tready falls once that register is full.
// Reset (rst, synchronous) clears the parser state, the magic register and both valid flags.
// The header byte store has no reset and needs no clearing pass.
module update_frame_deframer
  import ufd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // byte_valid, byte_data, reset_request, reply_taken, unused upper bits
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // consumed, phase, payload_strobe, payload_byte, payload_index,
  // frame_opcode, frame_length, header_fault, zero fill
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  result_t     out_res;
  result_t     result;
  logic        advance;
  logic [31:0] frame_magic;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (s_tvalid && s_tready) || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  ufd_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_magic (frame_magic)
  );

  ufd_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .frame_magic (frame_magic),
    .advance     (advance),
    .item        (in_item),
    .result      (result)
  );

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.frame_done;
  assign m_tdata  = {6'b0, out_res.header_fault, out_res.frame_length, out_res.frame_opcode,
                     out_res.payload_index, out_res.payload_byte, out_res.payload_strobe,
                     out_res.phase, out_res.consumed};

endmodule

@@ rtl/core/ufd_checker.sv @@
// Port-level checker for the update frame deframer and its bind.
module ufd_checker
  import ufd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Result changed while stalled.");

  a_strobe_consumed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[0])
    else $error("Payload strobe without a consumed byte.");

  a_done_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[2:1] == PH_REPLY)
    else $error("Frame done outside reply phase.");

  a_error_failed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[65] |-> m_tdata[2:1] == PH_FAILED && !m_tdata[3])
    else $error("Header fault without failed phase.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind update_frame_deframer ufd_checker u_ufd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ test/update_frame_deframer_tb.sv @@
// Self-checking testbench for update_frame_deframer with random framed byte streams.
`timescale 1ns / 1ps

module update_frame_deframer_tb;
  import ufd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  update_frame_deframer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  item_t byte_q[$];
  result_t expected_q[$];
  int mismatches = 0;
  int byte_count = 0;

  // Predictor state.
  logic [31:0] cfg_magic = '0;
  phase_t ph_now = PH_HEADER;
  int unsigned fill_now = 0;
  logic [127:0] hdr_bits = '0;
  logic [31:0] op_word = '0;
  logic [31:0] len_word = '0;
  logic reply_mark = 1'b0;

  // Handshake bookkeeping between the sampling edge and the driving edge.
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic drv_active = 1'b0;
  item_t drv_cur = '0;
  int drv_gap = 0;
  logic drv_calm = 1'b0;
  int rcv_gap = 0;
  logic rcv_calm = 1'b0;
  result_t want;

  function automatic result_t deframe_step(item_t it);
    result_t r;
    r = '0;
    if (it.reply_taken) reply_mark = 1'b1;
    if (it.reset_request) begin
      reply_mark = 1'b0;
      fill_now = 0;
      ph_now = PH_HEADER;
    end else begin
      case (ph_now)
        PH_HEADER: begin
          if (it.byte_valid && fill_now < HDR_BYTES) begin
            hdr_bits[8*fill_now +: 8] = it.byte_data;
            fill_now++;
            r.consumed = 1'b1;
          end
          if (fill_now == HDR_BYTES) begin
            op_word = hdr_bits[95:64];
            len_word = hdr_bits[127:96];
            if (hdr_bits[31:0] != cfg_magic || hdr_bits[63:32] != HDR_VERSION
                || len_word > PAYLOAD_BYTES_DEF) begin
              r.header_fault = 1'b1;
              ph_now = PH_FAILED;
            end else begin
              fill_now = 0;
              ph_now = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (it.byte_valid && fill_now < len_word) begin
            r.consumed = 1'b1;
            r.payload_strobe = 1'b1;
            r.payload_byte = it.byte_data;
            r.payload_index = 10'(fill_now);
            fill_now++;
          end
          if (fill_now >= len_word) begin
            r.frame_done = 1'b1;
            ph_now = PH_REPLY;
          end
        end
        PH_REPLY: begin
          if (reply_mark) begin
            reply_mark = 1'b0;
            fill_now = 0;
            ph_now = PH_HEADER;
          end
        end
        default: ;
      endcase
    end
    r.phase = ph_now;
    r.frame_opcode = op_word;
    r.frame_length = len_word[10:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val, got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    in_fire = !rst && s_tvalid && s_tready;
    out_fire = !rst && m_tvalid && m_tready;
    if (in_fire)
      expected_q.push_back(deframe_step(item_t'(s_tdata[$bits(item_t)-1:0])));
    if (out_fire) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result transfer with none expected", $time);
      end else begin
        want = expected_q.pop_front();
        check_field("consumed", 32'(want.consumed), 32'(m_tdata[0]));
        check_field("phase", 32'(want.phase), 32'(m_tdata[2:1]));
        check_field("payload_strobe", 32'(want.payload_strobe), 32'(m_tdata[3]));
        check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[11:4]));
        check_field("payload_index", 32'(want.payload_index), 32'(m_tdata[21:12]));
        check_field("frame_opcode", want.frame_opcode, m_tdata[53:22]);
        check_field("frame_length", 32'(want.frame_length), 32'(m_tdata[64:54]));
        check_field("header_fault", 32'(want.header_fault), 32'(m_tdata[65]));
        check_field("frame_done", 32'(want.frame_done), 32'(m_tlast));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (drv_active && in_fire) begin
        drv_active = 1'b0;
        if ($urandom_range(0, 29) == 0) drv_calm = !drv_calm;
        drv_gap = drv_calm ? 0 : $urandom_range(0, 11);
      end
      if (!drv_active) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (byte_q.size() > 0) begin
          drv_cur = byte_q.pop_front();
          drv_active = 1'b1;
        end
      end
      s_tvalid <= drv_active;
      s_tdata <= S_TDATA_W'(drv_cur);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) rcv_calm = !rcv_calm;
        rcv_gap = rcv_calm ? 0 : $urandom_range(0, 11);
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic bv, input logic [7:0] bd, input logic rr, rt);
    item_t it;
    it.byte_valid = bv;
    it.byte_data = bd;
    it.reset_request = rr;
    it.reply_taken = rt;
    byte_q.push_back(it);
  endtask

  task automatic add_frame(input logic [31:0] magic, ver, opc, len, input logic messy);
    logic [127:0] hdr;
    logic bad;
    logic early;
    logic cut;
    logic rt;
    int total;
    int abort_at;
    int mark_at;
    int i;
    hdr = {len, opc, ver, magic};
    bad = magic != cfg_magic || ver != HDR_VERSION || len > PAYLOAD_BYTES_DEF;
    total = bad ? 16 : 16 + int'(len);
    abort_at = -1;
    mark_at = -1;
    if (messy && $urandom_range(0, 11) == 0) abort_at = $urandom_range(0, total - 1);
    if (messy && !bad && $urandom_range(0, 3) == 0) mark_at = $urandom_range(0, total - 1);
    early = 1'b0;
    cut = 1'b0;
    i = 0;
    while (i < total && !cut) begin
      while (messy && $urandom_range(0, 9) == 0) push_item(1'b0, 8'($urandom), 1'b0, 1'b0);
      if (i == abort_at) begin
        push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
        cut = 1'b1;
      end else begin
        push_item(1'b1, i < 16 ? hdr[8*i +: 8] : 8'($urandom), 1'b0, i == mark_at);
        if (i == mark_at) early = 1'b1;
        byte_count++;
      end
      i++;
    end
    if (!cut) begin
      if (bad) begin
        repeat ($urandom_range(0, 3))
          push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0,
                    1'($urandom_range(0, 1)));
        push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
      end else begin
        if (len == 0) begin
          rt = ($urandom_range(0, 3) == 0);
          push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, rt);
          if (rt) early = 1'b1;
        end
        if (early) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0,
                    1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(0, 2))
            push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b0);
          push_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, 1'b1);
        end
      end
    end
  endtask

  task automatic add_random_frame();
    logic [31:0] magic;
    logic [31:0] ver;
    logic [31:0] len;
    int pick;
    magic = cfg_magic;
    if ($urandom_range(0, 9) == 0)
      magic = $urandom_range(0, 1) ? $urandom : cfg_magic ^ (32'd1 << $urandom_range(0, 31));
    ver = HDR_VERSION;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: ver = 32'd0;
        1: ver = 32'd2;
        2: ver = HDR_VERSION | (32'd1 << $urandom_range(1, 31));
        default: ver = $urandom;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      len = 32'd0;
    end else if (pick < 70) begin
      len = $urandom_range(1, 12);
    end else if (pick < 88) begin
      len = $urandom_range(13, 48);
    end else begin
      case ($urandom_range(0, 3))
        0: len = PAYLOAD_BYTES_DEF + 1;
        1: len = $urandom_range(1025, 2047);
        2: len = 32'hFFFF_FFFF;
        default: len = $urandom;
      endcase
    end
    add_frame(magic, ver, $urandom, len, 1'b1);
  endtask

  task automatic write_frame_magic(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_FRAME_MAGIC, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cfg_magic = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (byte_q.size() != 0 || drv_active || expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    logic [127:0] dir_hdr;
    logic [31:0] magic_plan [4];
    int phase_start;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Zero-length frame under the reset magic, with the reply mark given early.
    dir_hdr = {32'd0, 32'hFFFF_FFFF, HDR_VERSION, 32'd0};
    push_item(1'b0, 8'h00, 1'b0, 1'b1);
    for (int k = 0; k < 16; k++) push_item(1'b1, dir_hdr[8*k +: 8], 1'b0, 1'b0);
    push_item(1'b1, 8'hFF, 1'b0, 1'b0);
    push_item(1'b1, 8'hA5, 1'b0, 1'b0);
    push_item(1'b1, 8'h5A, 1'b1, 1'b1);
    push_item(1'b1, 8'h3C, 1'b0, 1'b0);
    push_item(1'b1, 8'hC3, 1'b0, 1'b0);
    push_item(1'b0, 8'hFF, 1'b1, 1'b0);
    wait_drained();

    magic_plan = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom};
    for (int p = 0; p < 4; p++) begin
      write_frame_magic(magic_plan[p]);
      if (p == 1) begin
        // A frame at the length limit, cut short in its payload by a reset request.
        dir_hdr = {32'(PAYLOAD_BYTES_DEF), 32'($urandom), HDR_VERSION, cfg_magic};
        for (int k = 0; k < 16; k++) push_item(1'b1, dir_hdr[8*k +: 8], 1'b0, 1'b0);
        repeat (4) push_item(1'b1, 8'($urandom), 1'b0, 1'b0);
        push_item(1'b0, 8'h00, 1'b1, 1'b0);
      end
      phase_start = byte_count;
      while (byte_count - phase_start < 75) add_random_frame();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("update_frame_deframer_tb: done, clean");
    end else begin
      $display("update_frame_deframer_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #800_000;
    $display("update_frame_deframer_tb: done, errors");
    $finish;
  end

endmodule
